/* hw/rtl/rfc_pkg.sv */
// Shared types and constants for the random forest classifier.
`default_nettype none
package rfc_pkg;

  localparam int IDX_W = 11;
  localparam int FEAT_IN_W = 32;

  localparam logic [1:0] FUNC_NODE = 2'd0;
  localparam logic [1:0] FUNC_ROOT = 2'd1;
  localparam logic [1:0] FUNC_CLASSIFY = 2'd2;

  localparam logic [1:0] SEL_A = 2'd0;
  localparam logic [1:0] SEL_B = 2'd1;
  localparam logic [1:0] SEL_C = 2'd2;

  localparam logic [4:0] VOTE_MAX = 5'd31;
  localparam logic [4:0] TREES_RESET = 5'd10;

  typedef struct packed {
    logic [1:0] func;
    logic [IDX_W-1:0] node_slot;
    logic [3:0] tree_slot;
    logic is_leaf;
    logic leaf_class;
    logic [1:0] feature_select;
    logic signed [FEAT_IN_W-1:0] split_value;
    logic [IDX_W-1:0] left_child;
    logic [IDX_W-1:0] right_child;
    logic signed [FEAT_IN_W-1:0] feature_a;
    logic signed [FEAT_IN_W-1:0] feature_b;
    logic signed [FEAT_IN_W-1:0] feature_c;
  } in_t;

  typedef struct packed {
    logic predicted;
    logic [4:0] ones_votes;
    logic [4:0] zeros_votes;
    logic walk_fault;
  } out_t;

  // One node table entry, 58 bits.
  typedef struct packed {
    logic is_leaf;
    logic leaf_class;
    logic [1:0] feature_select;
    logic [FEAT_IN_W-1:0] split_value;
    logic [IDX_W-1:0] left_child;
    logic [IDX_W-1:0] right_child;
  } node_t;

  // Sequencer commands to the datapath.
  typedef struct packed {
    logic idle;
    logic start;
    logic step;
    logic use_root;
    logic node_we;
    logic root_we;
  } ctrl_t;

  // Datapath status for the node just read.
  typedef struct packed {
    logic leaf;
    logic cls;
  } stat_t;

endpackage
`default_nettype wire

/* hw/rtl/rfc_dp.sv */
// Datapath: node and root memories, feature registers and the shared compare unit.
`default_nettype none
module rfc_dp #(
  parameter int NODE_ENTRIES = 2048,
  parameter int MAX_TREES = 16,
  parameter int FEATURE_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire rfc_pkg::in_t in_item,
  input  wire rfc_pkg::ctrl_t ctrl,
  output rfc_pkg::stat_t status
);
  import rfc_pkg::*;

  localparam int AW = (NODE_ENTRIES > 1) ? $clog2(NODE_ENTRIES) : 1;
  localparam int TW = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
  localparam logic [27:0] NE = 28'(NODE_ENTRIES);

  // Reduce a node index modulo the table size by restoring subtraction.
  function automatic logic [AW-1:0] wrap_idx(input logic [IDX_W-1:0] idx);
    logic [27:0] r;
    r = 28'(idx);
    for (int k = IDX_W - 1; k >= 0; k--) begin
      if (((NE << k) < 28'd2048) && (r >= (NE << k))) begin
        r = r - (NE << k);
      end
    end
    return r[AW-1:0];
  endfunction

  function automatic logic signed [FEATURE_WIDTH-1:0] ext_feat(
    input logic [FEAT_IN_W-1:0] v);
    logic [63:0] w;
    w = {{32{v[FEAT_IN_W-1]}}, v};
    return w[FEATURE_WIDTH-1:0];
  endfunction

  node_t node_mem [NODE_ENTRIES];
  logic [IDX_W-1:0] root_mem [MAX_TREES];

  node_t node_q_r;
  logic [IDX_W-1:0] root_q_r;
  logic [TW-1:0] rptr_r, rptr_nxt;
  logic signed [FEATURE_WIDTH-1:0] feat_a_r, feat_b_r, feat_c_r;
  logic signed [FEATURE_WIDTH-1:0] feat_sel, thresh;
  logic [IDX_W-1:0] child;
  logic [AW-1:0] rd_addr;
  logic [16:0] node_wa;
  logic [6:0] root_wa;

  assign node_wa = 17'(in_item.node_slot);
  assign root_wa = 7'(in_item.tree_slot);

  always_ff @(posedge clk) begin
    if (ctrl.node_we && (node_wa < 17'(NODE_ENTRIES))) begin
      node_mem[node_wa[AW-1:0]] <= '{
        is_leaf: in_item.is_leaf,
        leaf_class: in_item.leaf_class,
        feature_select: in_item.feature_select,
        split_value: in_item.split_value,
        left_child: in_item.left_child,
        right_child: in_item.right_child
      };
    end
    node_q_r <= node_mem[rd_addr];
  end

  // The root read runs one tree ahead so that a new walk starts without a bubble.
  always_comb begin
    if (ctrl.idle) begin
      rptr_nxt = '0;
    end else if (ctrl.step) begin
      rptr_nxt = rptr_r + TW'(1);
    end else begin
      rptr_nxt = rptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rptr_r <= '0;
    end else begin
      rptr_r <= rptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.root_we && (root_wa < 7'(MAX_TREES))) begin
      root_mem[root_wa[TW-1:0]] <= in_item.node_slot;
    end
    root_q_r <= root_mem[rptr_nxt];
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      feat_a_r <= ext_feat(in_item.feature_a);
      feat_b_r <= ext_feat(in_item.feature_b);
      feat_c_r <= ext_feat(in_item.feature_c);
    end
  end

  always_comb begin
    case (node_q_r.feature_select)
      SEL_A: feat_sel = feat_a_r;
      SEL_B: feat_sel = feat_b_r;
      SEL_C: feat_sel = feat_c_r;
      default: feat_sel = '0;
    endcase
  end

  assign thresh = ext_feat(node_q_r.split_value);
  assign child = (feat_sel < thresh) ? node_q_r.left_child : node_q_r.right_child;
  assign rd_addr = ctrl.use_root ? wrap_idx(root_q_r) : wrap_idx(child);

  assign status.leaf = node_q_r.is_leaf;
  assign status.cls = node_q_r.leaf_class;

endmodule
`default_nettype wire

/* hw/rtl/rfc_seq.sv */
// Sequencer: walk control, depth bound, vote counting and the result register.
`default_nettype none
module rfc_seq #(
  parameter int MAX_TREES = 16,
  parameter int DEPTH_BOUND = 12
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic accept,
  input  wire logic [1:0] func,
  input  wire logic [4:0] trees_in_use,
  input  wire rfc_pkg::stat_t status,
  output rfc_pkg::ctrl_t ctrl,
  output logic busy,
  output logic out_valid,
  output rfc_pkg::out_t out_item
);
  import rfc_pkg::*;

  localparam int CW = $clog2(MAX_TREES + 1);
  localparam int DW = $clog2(DEPTH_BOUND + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_FIN = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [CW-1:0] tree_r, tree_nxt, ntrees_r, ntrees_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [4:0] ones_r, ones_nxt, zeros_r, zeros_nxt;
  logic fault_r, fault_nxt;
  logic out_valid_r, out_valid_nxt;
  out_t out_r, out_nxt;
  logic classify;
  logic at_bound, more_trees;
  logic [6:0] tu_ext;

  assign classify = accept && (func == FUNC_CLASSIFY);
  assign tu_ext = 7'(trees_in_use);
  assign at_bound = (depth_r == DW'(DEPTH_BOUND));
  assign more_trees = (({1'b0, tree_r} + (CW + 1)'(1)) < {1'b0, ntrees_r});

  always_comb begin
    state_nxt = state_r;
    tree_nxt = tree_r;
    ntrees_nxt = ntrees_r;
    depth_nxt = depth_r;
    ones_nxt = ones_r;
    zeros_nxt = zeros_r;
    fault_nxt = fault_r;
    out_valid_nxt = 1'b0;
    out_nxt = out_r;
    ctrl.idle = (state_r == ST_IDLE);
    ctrl.start = classify;
    ctrl.node_we = accept && (func == FUNC_NODE);
    ctrl.root_we = accept && (func == FUNC_ROOT);
    ctrl.step = 1'b0;
    ctrl.use_root = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (classify) begin
          ntrees_nxt = (tu_ext > 7'(MAX_TREES)) ? CW'(MAX_TREES) : CW'(tu_ext);
          tree_nxt = '0;
          depth_nxt = '0;
          ones_nxt = '0;
          zeros_nxt = '0;
          fault_nxt = 1'b0;
          state_nxt = (tu_ext == 7'd0) ? ST_FIN : ST_START;
        end
      end
      ST_START: begin
        ctrl.use_root = 1'b1;
        ctrl.step = 1'b1;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (status.leaf || at_bound) begin
          if (status.leaf) begin
            if (status.cls) begin
              ones_nxt = (ones_r != VOTE_MAX) ? ones_r + 5'd1 : ones_r;
            end else begin
              zeros_nxt = (zeros_r != VOTE_MAX) ? zeros_r + 5'd1 : zeros_r;
            end
          end else begin
            fault_nxt = 1'b1;
          end
          if (more_trees) begin
            tree_nxt = tree_r + CW'(1);
            depth_nxt = '0;
            ctrl.use_root = 1'b1;
            ctrl.step = 1'b1;
          end else begin
            state_nxt = ST_FIN;
          end
        end else begin
          depth_nxt = depth_r + DW'(1);
        end
      end
      ST_FIN: begin
        out_valid_nxt = 1'b1;
        out_nxt.predicted = (ones_r > zeros_r);
        out_nxt.ones_votes = ones_r;
        out_nxt.zeros_votes = zeros_r;
        out_nxt.walk_fault = fault_r;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tree_r <= '0;
      ntrees_r <= '0;
      depth_r <= '0;
      ones_r <= '0;
      zeros_r <= '0;
      fault_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tree_r <= tree_nxt;
      ntrees_r <= ntrees_nxt;
      depth_r <= depth_nxt;
      ones_r <= ones_nxt;
      zeros_r <= zeros_nxt;
      fault_r <= fault_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign busy = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item = out_r;

endmodule
`default_nettype wire

/* hw/rtl/random_forest_classify_top.sv */
// Top level of the random forest classifier.
`default_nettype none
// Usage:
//   Items enter on in_item with start; a transaction is taken at a clock edge
//   where start is high and busy is low. A node write (func 0) or root write
//   (func 1) completes at that edge and returns no result; busy stays low.
//   A classify item (func 2) raises busy and walks each tree in use from its
//   root, one node memory read per cycle, and reads at most DEPTH_BOUND + 1
//   nodes per tree; the single node memory read port sets the pace. With
//   no tree in use the walk is skipped and the block goes straight to the
//   result state.
//   The result appears on out_item for one cycle with out_valid high and must
//   be taken then; the receiver cannot stall it. Unused func codes are dropped.
//   The cfg channel writes trees_in_use (cfg_ready is high while idle).
//   Reset is synchronous and active low: it returns the block to idle and sets
//   trees_in_use to 10. Node and root tables are not cleared and must be
//   loaded before classifying.
module random_forest_classify_top #(
  parameter int NODE_ENTRIES = 2048,
  parameter int MAX_TREES = 16,
  parameter int DEPTH_BOUND = 12,
  parameter int FEATURE_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic busy,
  input  wire rfc_pkg::in_t in_item,
  output logic out_valid,
  output rfc_pkg::out_t out_item,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [4:0] cfg_data
);
  import rfc_pkg::*;

  logic [4:0] trees_r;
  logic accept;
  ctrl_t ctrl;
  stat_t status;

  assign accept = start && !busy;
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trees_r <= TREES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      trees_r <= cfg_data;
    end
  end

  rfc_seq #(
    .MAX_TREES(MAX_TREES),
    .DEPTH_BOUND(DEPTH_BOUND)
  ) u_seq (
    .clk(clk),
    .rst_n(rst_n),
    .accept(accept),
    .func(in_item.func),
    .trees_in_use(trees_r),
    .status(status),
    .ctrl(ctrl),
    .busy(busy),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  rfc_dp #(
    .NODE_ENTRIES(NODE_ENTRIES),
    .MAX_TREES(MAX_TREES),
    .FEATURE_WIDTH(FEATURE_WIDTH)
  ) u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .in_item(in_item),
    .ctrl(ctrl),
    .status(status)
  );

endmodule
`default_nettype wire
